[hw/rtl/avt_pkg.sv]
// Shared constants and codes for the affine vector transform.
`timescale 1ns / 1ps

package avt_pkg;

   localparam int VEC_MAX        = 64;
   localparam int NUM_TRANSFORMS = 16;

   // Fixed field widths of the request and response payloads
   localparam int FUNC_W      = 2;
   localparam int TIDX_W      = 4;
   localparam int FIELD_IDX_W = 6;
   localparam int VALUE_W     = 32;

   // Internal widths derived from the vector length
   localparam int IDX_W = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
   localparam int CNT_W = $clog2(VEC_MAX + 1);

   localparam int COEF_DEPTH = NUM_TRANSFORMS * VEC_MAX * VEC_MAX;
   localparam int BIAS_DEPTH = NUM_TRANSFORMS * VEC_MAX;
   localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

   // Products are 64 bits; headroom for VEC_MAX of them plus the bias
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = PROD_W + IDX_W + 2;
   localparam int FRAC_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_COEF = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BIAS = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_VEC  = 2'd2;

endpackage

[hw/rtl/avt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module avt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/affine_vector_transform.sv]
// Top level: coefficient banks, vector buffer and shared MAC sequencer for y = A*x + b.
`timescale 1ns / 1ps

//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | func, transform_index, row_index, col_index,
//          |           |                   | value, skip, last
//  rsp     | out       | rsp_valid/stall   | out_value, out_index, out_last
//
//  Load items and non-final vector items do not raise req_stall.
//  A final vector item of length L keeps req_stall high until its last result is
//  handed on: one shared 32x32 multiplier does L MACs per output element, through
//  RAM read, multiply and accumulate registers; a skipped vector does one per element.
//  Synchronous reset clears the sequencer, element count, pipeline valids, done flag and response valid only.
//  rsp_stall holds the response register; the sequencer waits before overwriting it.

module affine_vector_transform
   import avt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [FUNC_W-1:0]             req_func,
   input  logic [TIDX_W-1:0]             req_transform_index,
   input  logic [FIELD_IDX_W-1:0]        req_row_index,
   input  logic [FIELD_IDX_W-1:0]        req_col_index,
   input  logic signed [VALUE_W-1:0]     req_value,
   input  logic                          req_skip,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_W-1:0]     rsp_out_value,
   output logic [FIELD_IDX_W-1:0]        rsp_out_index,
   output logic                          rsp_out_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [TIDX_W-1:0] tidx_ff, tidx_in;
   logic              skip_ff, skip_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic              p1_vld_ff, p1_vld_in;
   logic              p1_first_ff, p1_first_in;
   logic              p1_end_ff, p1_end_in;
   logic              p2_vld_ff, p2_vld_in;
   logic              p2_first_ff, p2_first_in;
   logic              p2_end_ff, p2_end_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [VALUE_W-1:0] bias_ff, bias_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [FIELD_IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_take;
   logic                      out_free;
   logic                      mac_end;
   logic                      row_last;
   logic                      acc_fits;
   logic [CNT_W-1:0]          cnt_sat;
   logic signed [VALUE_W-1:0] sat_value;

   logic                      coef_we, bias_we, vbuf_we, rd_en;
   logic [COEF_AW-1:0]        coef_waddr, coef_raddr;
   logic [BIAS_AW-1:0]        bias_waddr, bias_raddr;
   logic [IDX_W-1:0]          vbuf_waddr, vbuf_raddr;
   logic [VALUE_W-1:0]        coef_rd, bias_rd, vbuf_rd;
   logic signed [VALUE_W-1:0] coef_q, bias_q, vbuf_q;

   assign coef_q = signed'(coef_rd);
   assign bias_q = signed'(bias_rd);
   assign vbuf_q = signed'(vbuf_rd);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // host loads and vector element capture
   assign coef_we = req_take && (req_func == FUNC_COEF)
                    && (int'(req_transform_index) < NUM_TRANSFORMS)
                    && (int'(req_row_index) < VEC_MAX) && (int'(req_col_index) < VEC_MAX);
   assign bias_we = req_take && (req_func == FUNC_BIAS)
                    && (int'(req_transform_index) < NUM_TRANSFORMS)
                    && (int'(req_row_index) < VEC_MAX);
   assign vbuf_we = req_take && (req_func == FUNC_VEC) && (int'(req_col_index) < VEC_MAX);

   assign coef_waddr = COEF_AW'((int'(req_transform_index) * VEC_MAX + int'(req_row_index))
                                * VEC_MAX + int'(req_col_index));
   assign bias_waddr = BIAS_AW'(int'(req_transform_index) * VEC_MAX + int'(req_row_index));
   assign vbuf_waddr = req_col_index[IDX_W-1:0];

   // MAC issue addresses
   assign rd_en      = (state_ff == ST_MAC);
   assign coef_raddr = COEF_AW'((int'(tidx_ff) * VEC_MAX + int'(row_ff)) * VEC_MAX
                                + int'(col_ff));
   assign bias_raddr = BIAS_AW'(int'(tidx_ff) * VEC_MAX + int'(row_ff));
   assign vbuf_raddr = skip_ff ? row_ff : col_ff;

   assign mac_end  = skip_ff || (int'(col_ff) == int'(len_ff) - 1);
   assign row_last = (int'(row_ff) == int'(len_ff) - 1);
   assign cnt_sat  = (int'(count_ff) < VEC_MAX) ? CNT_W'(count_ff + 1'b1) : count_ff;

   // floor shift by the fraction width, then saturate to 32 bits
   assign acc_fits  = (&acc_ff[ACC_W-1:FRAC_W+VALUE_W-1])
                      || !(|acc_ff[ACC_W-1:FRAC_W+VALUE_W-1]);
   assign sat_value = acc_fits ? acc_ff[FRAC_W+VALUE_W-1:FRAC_W]
                    : (acc_ff[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      tidx_in      = tidx_ff;
      skip_in      = skip_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      p1_vld_in    = 1'b0;
      p1_first_in  = p1_first_ff;
      p1_end_in    = p1_end_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_func == FUNC_VEC)) begin
               if (req_last) begin
                  count_in = '0;
                  len_in   = cnt_sat;
                  tidx_in  = req_transform_index;
                  skip_in  = req_skip || (int'(req_transform_index) >= NUM_TRANSFORMS);
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_MAC;
               end else begin
                  count_in = cnt_sat;
               end
            end
         end
         ST_MAC: begin
            p1_vld_in   = 1'b1;
            p1_first_in = skip_ff || (col_ff == '0);
            p1_end_in   = mac_end;
            if (mac_end) begin
               state_in = ST_WAIT;
            end else begin
               col_in = IDX_W'(col_ff + 1'b1);
            end
         end
         ST_WAIT: begin
            // hand the finished sum to the response register once it is free
            if (done_ff && out_free) begin
               done_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_value_in = sat_value;
               rsp_index_in = FIELD_IDX_W'(row_ff);
               rsp_last_in  = row_last;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = IDX_W'(row_ff + 1'b1);
                  col_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // multiply stage; a skipped element is scaled so the shift returns it as is
      p2_vld_in   = p1_vld_ff;
      p2_first_in = p1_first_ff;
      p2_end_in   = p1_end_ff;
      prod_in     = skip_ff ? (PROD_W'(vbuf_q) <<< FRAC_W) : coef_q * vbuf_q;
      bias_in     = skip_ff ? '0 : bias_q;

      // accumulate stage
      acc_in = acc_ff;
      if (p2_vld_ff) begin
         acc_in = (p2_first_ff ? (ACC_W'(bias_ff) <<< FRAC_W) : acc_ff) + ACC_W'(prod_ff);
         if (p2_end_ff) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      tidx_ff      <= tidx_in;
      skip_ff      <= skip_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      p1_first_ff  <= p1_first_in;
      p1_end_ff    <= p1_end_in;
      p2_first_ff  <= p2_first_in;
      p2_end_ff    <= p2_end_in;
      prod_ff      <= prod_in;
      bias_ff      <= bias_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_last  = rsp_last_ff;

   avt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (coef_raddr),
      .rd_data (coef_rd)
   );

   avt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (BIAS_DEPTH)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (bias_waddr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (bias_raddr),
      .rd_data (bias_rd)
   );

   avt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (VEC_MAX)
   ) u_vbuf_ram (
      .clock   (clock),
      .wr_en   (vbuf_we),
      .wr_addr (vbuf_waddr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (vbuf_raddr),
      .rd_data (vbuf_rd)
   );

endmodule

[bench/testbench.sv]
// Self-checking bench for the affine vector transform: queued stimulus and predictor.
`timescale 1ns / 1ps

module testbench
   import avt_pkg::*;
();

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 420;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam int MAX_REPORTS   = 10;
   localparam int ACC_BITS      = 80;
   localparam logic signed [ACC_BITS-1:0] SAT_HI = 80'sh7FFF_FFFF;
   localparam logic signed [ACC_BITS-1:0] SAT_LO = -80'sh8000_0000;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [TIDX_W-1:0]         tidx;
      logic [FIELD_IDX_W-1:0]    row;
      logic [FIELD_IDX_W-1:0]    col;
      logic signed [VALUE_W-1:0] value;
      logic                      skip;
      logic                      last;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [FIELD_IDX_W-1:0]    index;
      logic                      last;
   } elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   req_item_type req_item = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [FIELD_IDX_W-1:0]    rsp_out_index;
   logic                      rsp_out_last;

   // Predictor state
   logic [VALUE_W-1:0] tf_coef [0:COEF_DEPTH-1];
   logic [VALUE_W-1:0] tf_bias [0:BIAS_DEPTH-1];
   logic [VALUE_W-1:0] vec_buf [0:VEC_MAX-1];
   int                 elem_count = 0;

   // Stimulus bookkeeping: which store entries have been loaded so far
   bit coef_loaded [0:COEF_DEPTH-1];
   bit bias_loaded [0:BIAS_DEPTH-1];

   req_item_type pending_reqs[$];
   elem_type     expected_elems[$];
   int        stim_count = 0;
   int        issued = 0;
   int        mark1 = 0;
   int        mark2 = 0;
   int        fault_count = 0;
   int        result_count = 0;
   int        quiet_cycles = 0;

   affine_vector_transform dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_item.func),
      .req_transform_index (req_item.tidx),
      .req_row_index       (req_item.row),
      .req_col_index       (req_item.col),
      .req_value           (req_item.value),
      .req_skip            (req_item.skip),
      .req_last            (req_item.last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_value       (rsp_out_value),
      .rsp_out_index       (rsp_out_index),
      .rsp_out_last        (rsp_out_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int coef_addr(int t, int r, int c);
      return (t * VEC_MAX + r) * VEC_MAX + c;
   endfunction

   function automatic int bias_addr(int t, int r);
      return t * VEC_MAX + r;
   endfunction

   function automatic int sender_idle_pct();
      if (issued < mark1) return 27;
      if (issued < mark2) return 82;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (issued < mark1) return 82;
      if (issued < mark2) return 27;
      return 0;
   endfunction

   // Modest Q16.16 magnitudes in nearly half the draws, with extremes and full-range noise mixed in
   function automatic logic [VALUE_W-1:0] rand_q16();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
         endcase
      end
      if (roll < 60) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      return $urandom();
   endfunction

   // Work out the results that one accepted transfer causes
   function automatic void predict_affine(req_item_type it);
      int                          len;
      bit                          pass_through;
      logic signed [VALUE_W-1:0]   c;
      logic signed [VALUE_W-1:0]   x;
      logic signed [2*VALUE_W-1:0] prod;
      logic signed [ACC_BITS-1:0]  acc;
      logic signed [ACC_BITS-1:0]  bias_term;
      elem_type                    e;
      case (it.func)
         FUNC_COEF: begin
            if (int'(it.tidx) < NUM_TRANSFORMS && int'(it.row) < VEC_MAX
                && int'(it.col) < VEC_MAX)
               tf_coef[coef_addr(it.tidx, it.row, it.col)] = it.value;
         end
         FUNC_BIAS: begin
            if (int'(it.tidx) < NUM_TRANSFORMS && int'(it.row) < VEC_MAX)
               tf_bias[bias_addr(it.tidx, it.row)] = it.value;
         end
         FUNC_VEC: begin
            if (int'(it.col) < VEC_MAX) vec_buf[it.col] = it.value;
            if (elem_count < VEC_MAX) elem_count++;
            if (it.last) begin
               len = elem_count;
               elem_count = 0;
               pass_through = it.skip || int'(it.tidx) >= NUM_TRANSFORMS;
               for (int l = 0; l < len; l++) begin
                  if (pass_through) begin
                     e.value = vec_buf[l];
                  end else begin
                     acc = '0;
                     for (int m = 0; m < len; m++) begin
                        c = tf_coef[coef_addr(it.tidx, l, m)];
                        x = vec_buf[m];
                        prod = c * x;
                        acc += prod;
                     end
                     bias_term = $signed(tf_bias[bias_addr(it.tidx, l)]);
                     acc += bias_term <<< FRAC_W;
                     // floor, then clamp to 32 bits
                     acc = acc >>> FRAC_W;
                     if (acc > SAT_HI) e.value = 32'h7FFF_FFFF;
                     else if (acc < SAT_LO) e.value = 32'h8000_0000;
                     else e.value = acc[VALUE_W-1:0];
                  end
                  e.index = FIELD_IDX_W'(l);
                  e.last  = (l == len - 1);
                  expected_elems.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_item(logic [FUNC_W-1:0] func, int t, int row, int col,
                                      logic [VALUE_W-1:0] value, bit skip, bit last);
      req_item_type it;
      it.func  = func;
      it.tidx  = TIDX_W'(t);
      it.row   = FIELD_IDX_W'(row);
      it.col   = FIELD_IDX_W'(col);
      it.value = value;
      it.skip  = skip;
      it.last  = last;
      pending_reqs.push_back(it);
      if (func == FUNC_COEF) coef_loaded[coef_addr(t, row, col)] = 1'b1;
      if (func == FUNC_BIAS) bias_loaded[bias_addr(t, row)] = 1'b1;
      if (func != FUNC_UNUSED) stim_count++;
   endfunction

   // Ignored codes, or loads anywhere with the last flag set
   function automatic void queue_noise();
      if ($urandom_range(1))
         queue_item(FUNC_UNUSED, $urandom_range(15), $urandom_range(63), $urandom_range(63),
                    $urandom(), bit'($urandom_range(1)), bit'($urandom_range(1)));
      else
         queue_item($urandom_range(1) ? FUNC_COEF : FUNC_BIAS, $urandom_range(15),
                    $urandom_range(63), $urandom_range(63), rand_q16(),
                    bit'($urandom_range(1)), 1'b1);
   endfunction

   // Load every coefficient and bias entry a vector of this length will read
   function automatic void ensure_transform(int t, int len);
      for (int r = 0; r < len; r++) begin
         for (int c = 0; c < len; c++)
            if (!coef_loaded[coef_addr(t, r, c)])
               queue_item(FUNC_COEF, t, r, c, rand_q16(), 1'b0, 1'b0);
         if (!bias_loaded[bias_addr(t, r)])
            queue_item(FUNC_BIAS, t, r, $urandom_range(63), rand_q16(), 1'b0, 1'b0);
      end
   endfunction

   // Transform and skip count only on the final element
   function automatic void queue_vector(int t, int n_items, bit skip, bit in_order, bit noisy);
      int col;
      bit fin;
      for (int i = 0; i < n_items; i++) begin
         if (noisy && $urandom_range(99) < 10) queue_noise();
         col = (in_order || $urandom_range(99) < 85) ? i % VEC_MAX : $urandom_range(VEC_MAX - 1);
         fin = (i == n_items - 1);
         queue_item(FUNC_VEC, fin ? t : $urandom_range(15), $urandom_range(63), col, rand_q16(),
                    fin ? skip : bit'($urandom_range(1)), fin);
      end
   endfunction

   initial begin
      int len;
      int n_items;
      int t;
      int roll;
      int directed_end;
      int random_end;
      bit skip;

      // Run the element count past its limit; fills every buffer entry before any read
      queue_vector(0, VEC_MAX + 6, 1'b1, 1'b1, 1'b0);
      // Single-element vectors: positive and negative saturation, floor of a tiny negative
      queue_item(FUNC_COEF, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 1'b1);
      queue_item(FUNC_BIAS, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 1'b1);
      queue_item(FUNC_UNUSED, 0, 0, 0, 32'h7FFF_FFFF, 1'b1, 1'b1);
      queue_item(FUNC_VEC, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 1'b1);
      queue_item(FUNC_COEF, 0, 0, 0, 32'h8000_0000, 1'b0, 1'b0);
      queue_item(FUNC_VEC, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 1'b1);
      queue_item(FUNC_COEF, 0, 0, 0, 32'h0000_0001, 1'b0, 1'b0);
      queue_item(FUNC_BIAS, 0, 0, 0, 32'h0000_0000, 1'b0, 1'b0);
      queue_item(FUNC_VEC, 0, 63, 0, 32'hFFFF_FFFF, 1'b0, 1'b1);
      // Skip on an early element is ignored; skip on the final one passes through
      ensure_transform(0, 2);
      queue_item(FUNC_VEC, 3, 0, 1, 32'h8000_0000, 1'b1, 1'b0);
      queue_item(FUNC_VEC, 0, 0, 0, 32'h0001_0000, 1'b0, 1'b1);
      queue_item(FUNC_VEC, 0, 0, 0, 32'h0001_8000, 1'b0, 1'b0);
      queue_item(FUNC_VEC, 0, 0, 1, 32'hFFFF_8000, 1'b1, 1'b1);
      directed_end = pending_reqs.size();

      random_end = RANDOM_ITEMS;
      while (stim_count < random_end) begin
         if ($urandom_range(99) < 8) begin
            queue_noise();
         end else begin
            roll = $urandom_range(99);
            if (roll < 70) len = $urandom_range(4, 1);
            else if (roll < 93) len = $urandom_range(12, 5);
            else len = $urandom_range(1) ? VEC_MAX : $urandom_range(VEC_MAX, 13);
            skip = ($urandom_range(99) < 20);
            t = $urandom_range(NUM_TRANSFORMS - 1);
            // keep matrix loads within the item budget
            if (!skip && len > 12) len = $urandom_range(12, 5);
            while (!skip && len > 1 && len * (len + 2) > random_end - stim_count) len--;
            n_items = len;
            if (skip && len == VEC_MAX) n_items += $urandom_range(6);
            if (!skip) begin
               ensure_transform(t, len);
               repeat ($urandom_range(2))
                  queue_item(FUNC_COEF, t, $urandom_range(len - 1), $urandom_range(len - 1),
                             rand_q16(), 1'b0, 1'b0);
               if ($urandom_range(3) == 0)
                  queue_item(FUNC_BIAS, t, $urandom_range(len - 1), $urandom_range(63),
                             rand_q16(), 1'b0, 1'b0);
            end
            queue_vector(t, n_items, skip, 1'b0, 1'b1);
         end
      end
      mark1 = directed_end + (pending_reqs.size() - directed_end) / 3;
      mark2 = directed_end + 2 * (pending_reqs.size() - directed_end) / 3;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0 && expected_elems.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Driver: hold a stalled transfer, otherwise present the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_affine(req_item);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               req_item  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               issued    <= issued + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void report_fault(string what, elem_type want, elem_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s at result %0d: expected value %h index %0d last %b,",
                  $time, what, result_count, want.value, want.index, want.last,
                  " got value %h index %0d last %b", got.value, got.index, got.last);
   endfunction

   // Monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      elem_type want;
      elem_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.value = rsp_out_value;
            got.index = rsp_out_index;
            got.last  = rsp_out_last;
            if (expected_elems.size() == 0) begin
               report_fault("unexpected result", '0, got);
            end else begin
               want = expected_elems.pop_front();
               if (got.value !== want.value || got.index !== want.index
                   || got.last !== want.last)
                  report_fault("mismatch", want, got);
            end
            result_count++;
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule
